// ===== hw/rtl/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpp_pkg: shared types and arithmetic helpers of the particle push unit
// Q16.16 rounding and saturation, the stage numbering of the pipeline and
// the record that travels down it.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int unsigned DivSteps  = 33;
  localparam int unsigned StgKick   = 0;
  localparam int unsigned StgVm     = 1;
  localparam int unsigned StgRot1   = 2;
  localparam int unsigned StgVp     = 3;
  localparam int unsigned StgDivIn  = 4;
  localparam int unsigned StgDiv0   = 5;
  localparam int unsigned StgSgn    = StgDiv0 + DivSteps;
  localparam int unsigned StgRot2   = StgSgn + 1;
  localparam int unsigned StgVq     = StgRot2 + 1;
  localparam int unsigned StgUn     = StgVq + 1;
  localparam int unsigned StgMove   = StgUn + 1;
  localparam int unsigned StgPos    = StgMove + 1;
  localparam int unsigned NumStages = StgPos + 1;

  localparam logic [2:0] CfgTimeStep = 3'd0;
  localparam logic [2:0] CfgHalfQm   = 3'd1;
  localparam logic [2:0] CfgLimX     = 3'd2;
  localparam logic [2:0] CfgLimY     = 3'd3;
  localparam logic [2:0] CfgLimZ     = 3'd4;
  localparam logic [2:0] CfgUpdPos   = 3'd5;

  // Element 0 is x, 1 is y, 2 is z. Values are two's complement bit patterns.
  typedef struct packed {
    logic [2:0][31:0] r;
    logic [2:0][31:0] u;
    logic [2:0][31:0] k;
    logic [2:0][31:0] vm;
    logic [2:0][31:0] t;
    logic [2:0][31:0] vp;
    logic [2:0][31:0] s;
    logic [2:0][31:0] un;
    logic [31:0]      den;
    logic [2:0]       neg;
    logic [2:0][31:0] rem;
    logic [2:0][32:0] dvd;
    logic [2:0][32:0] quo;
    logic [5:0][63:0] prd;
    logic [2:0][63:0] sq;
    logic             over;
  } pp_t;

  function automatic logic [63:0] mulq(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return p;
  endfunction

  // floor((p + 2^15) / 2^16)
  function automatic logic [48:0] rnd16(input logic [63:0] p);
    logic signed [64:0] x;
    x = $signed({p[63], p}) + 65'sd32768;
    return x[64:16];
  endfunction

  function automatic logic [31:0] sat32(input logic [49:0] v);
    logic signed [49:0] sv;
    sv = $signed(v);
    if (sv > 50'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (sv < -50'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic [49:0] ext32(input logic [31:0] a);
    return {{18{a[31]}}, a};
  endfunction

  function automatic logic [49:0] ext49(input logic [48:0] a);
    return {a[48], a};
  endfunction

  // SAT(base + R(p) - R(q))
  function automatic logic [31:0] cross_add(input logic [31:0] base, input logic [63:0] p,
                                            input logic [63:0] q);
    return sat32(ext32(base) + ext49(rnd16(p)) - ext49(rnd16(q)));
  endfunction

endpackage

// ===== hw/rtl/boris_particle_push_unit.sv =====
// ----------------------------------------------------------------------------
// boris_particle_push_unit: pipelined Boris particle pusher, Q16.16
// One particle in, one pushed particle out, saturating fixed point.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: valid_i / stall_o with one beat per particle carrying
//   position, velocity, electric and magnetic field. Output channel:
//   valid_o / stall_i with one beat per particle carrying the new position,
//   the new velocity and the speed flag.
//   Throughput: one particle per cycle while stall_i does not hold the output
//   beat; every stage is a register stage and the 33 quotient bits of
//   s = 2t/(1+|t|^2) are resolved one per stage.
//   Stalls: while the output beat is held by stall_i the whole pipeline
//   freezes and stall_o is raised; a bubble in the last stage lets the
//   pipeline advance, so empty slots are filled while the receiver waits.
//   Reset: empties the pipeline and loads the register defaults (dt = 0,
//   h = 0, speed limits at full scale, position update on).
//   Configuration: write cfg_we_i / cfg_idx_i / cfg_data_i only while the
//   pipeline is empty; unused indexes are dropped.
// ----------------------------------------------------------------------------
module boris_particle_push_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [31:0] efield_x_i,
  input  logic [31:0] efield_y_i,
  input  logic [31:0] efield_z_i,
  input  logic [31:0] bfield_x_i,
  input  logic [31:0] bfield_y_i,
  input  logic [31:0] bfield_z_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] new_pos_x_o,
  output logic [31:0] new_pos_y_o,
  output logic [31:0] new_pos_z_o,
  output logic [31:0] new_vel_x_o,
  output logic [31:0] new_vel_y_o,
  output logic [31:0] new_vel_z_o,
  output logic        speed_exceeded_o
);

  localparam int unsigned Last = bpp_pkg::NumStages - 1;

  // Configuration registers
  logic [31:0]      time_step_q;
  logic [31:0]      half_qm_q;
  logic [2:0][30:0] lim_q;
  logic             upd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= '0;
      half_qm_q   <= '0;
      lim_q       <= {3{31'h7fff_ffff}};
      upd_q       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpp_pkg::CfgTimeStep: time_step_q <= cfg_data_i;
        bpp_pkg::CfgHalfQm:   half_qm_q   <= cfg_data_i;
        bpp_pkg::CfgLimX:     lim_q[0]    <= cfg_data_i[30:0];
        bpp_pkg::CfgLimY:     lim_q[1]    <= cfg_data_i[30:0];
        bpp_pkg::CfgLimZ:     lim_q[2]    <= cfg_data_i[30:0];
        bpp_pkg::CfgUpdPos:   upd_q       <= cfg_data_i[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Pipeline
  bpp_pkg::pp_t st_q [bpp_pkg::NumStages];
  bpp_pkg::pp_t st_d [bpp_pkg::NumStages];
  logic         vld_q [bpp_pkg::NumStages];
  logic         adv;

  // Advance unless the output beat is held.
  assign adv     = !(vld_q[Last] && stall_i);
  assign stall_o = !adv;

  always_comb begin
    int unsigned a1;
    int unsigned a2;
    logic [49:0] acc;
    logic [32:0] mag;
    logic [48:0] m;
    logic [31:0] rsh;
    logic [32:0] diff;
    logic [49:0] qe;
    logic [31:0] um;
    logic        over;

    for (int unsigned i = 1; i < bpp_pkg::NumStages; i++) begin
      st_d[i] = st_q[i-1];
    end

    // Field products: t = R(B*h), k = R(h*E)
    st_d[bpp_pkg::StgKick]      = '0;
    st_d[bpp_pkg::StgKick].r    = {pos_z_i, pos_y_i, pos_x_i};
    st_d[bpp_pkg::StgKick].u    = {vel_z_i, vel_y_i, vel_x_i};
    st_d[bpp_pkg::StgKick].prd[0] = bpp_pkg::mulq(bfield_x_i, half_qm_q);
    st_d[bpp_pkg::StgKick].prd[1] = bpp_pkg::mulq(bfield_y_i, half_qm_q);
    st_d[bpp_pkg::StgKick].prd[2] = bpp_pkg::mulq(bfield_z_i, half_qm_q);
    st_d[bpp_pkg::StgKick].prd[3] = bpp_pkg::mulq(half_qm_q, efield_x_i);
    st_d[bpp_pkg::StgKick].prd[4] = bpp_pkg::mulq(half_qm_q, efield_y_i);
    st_d[bpp_pkg::StgKick].prd[5] = bpp_pkg::mulq(half_qm_q, efield_z_i);

    // Round, saturate and apply the first half kick.
    for (int unsigned d = 0; d < 3; d++) begin
      st_d[bpp_pkg::StgVm].t[d] =
        bpp_pkg::sat32(bpp_pkg::ext49(bpp_pkg::rnd16(st_q[bpp_pkg::StgKick].prd[d])));
      st_d[bpp_pkg::StgVm].k[d] =
        bpp_pkg::sat32(bpp_pkg::ext49(bpp_pkg::rnd16(st_q[bpp_pkg::StgKick].prd[3+d])));
      st_d[bpp_pkg::StgVm].vm[d] =
        bpp_pkg::sat32(bpp_pkg::ext32(st_q[bpp_pkg::StgKick].u[d]) +
                       bpp_pkg::ext32(st_d[bpp_pkg::StgVm].k[d]));
    end

    // vm x t products and |t|^2 terms
    for (int unsigned d = 0; d < 3; d++) begin
      a1 = (d == 2) ? 0 : d + 1;
      a2 = (d == 0) ? 2 : d - 1;
      st_d[bpp_pkg::StgRot1].prd[2*d] =
        bpp_pkg::mulq(st_q[bpp_pkg::StgVm].vm[a1], st_q[bpp_pkg::StgVm].t[a2]);
      st_d[bpp_pkg::StgRot1].prd[2*d+1] =
        bpp_pkg::mulq(st_q[bpp_pkg::StgVm].vm[a2], st_q[bpp_pkg::StgVm].t[a1]);
      st_d[bpp_pkg::StgRot1].sq[d] =
        bpp_pkg::mulq(st_q[bpp_pkg::StgVm].t[d], st_q[bpp_pkg::StgVm].t[d]);
    end

    // Denominator and first rotation
    acc = 50'd65536;
    for (int unsigned d = 0; d < 3; d++) begin
      acc = acc + bpp_pkg::ext49(bpp_pkg::rnd16(st_q[bpp_pkg::StgRot1].sq[d]));
      st_d[bpp_pkg::StgVp].vp[d] = bpp_pkg::cross_add(st_q[bpp_pkg::StgRot1].vm[d],
                                                      st_q[bpp_pkg::StgRot1].prd[2*d],
                                                      st_q[bpp_pkg::StgRot1].prd[2*d+1]);
    end
    st_d[bpp_pkg::StgVp].den = bpp_pkg::sat32(acc);

    // Divider set-up: dividend |2^17 t| + den/2, sign held aside
    for (int unsigned d = 0; d < 3; d++) begin
      mag = st_q[bpp_pkg::StgVp].t[d][31] ?
            33'd0 - {1'b1, st_q[bpp_pkg::StgVp].t[d]} : {1'b0, st_q[bpp_pkg::StgVp].t[d]};
      m = {mag[31:0], 17'd0} + {18'd0, st_q[bpp_pkg::StgVp].den[31:1]};
      if (mag[32]) begin
        m = {1'b1, 48'd0} + {18'd0, st_q[bpp_pkg::StgVp].den[31:1]};
      end
      st_d[bpp_pkg::StgDivIn].neg[d] = st_q[bpp_pkg::StgVp].t[d][31];
      st_d[bpp_pkg::StgDivIn].rem[d] = {16'd0, m[48:33]};
      st_d[bpp_pkg::StgDivIn].dvd[d] = m[32:0];
      st_d[bpp_pkg::StgDivIn].quo[d] = '0;
    end

    // Restoring division, one quotient bit per stage
    for (int unsigned i = bpp_pkg::StgDiv0; i < bpp_pkg::StgSgn; i++) begin
      for (int unsigned d = 0; d < 3; d++) begin
        rsh  = {st_q[i-1].rem[d][30:0], st_q[i-1].dvd[d][32]};
        diff = {1'b0, rsh} - {1'b0, st_q[i-1].den};
        st_d[i].rem[d] = diff[32] ? rsh : diff[31:0];
        st_d[i].quo[d] = {st_q[i-1].quo[d][31:0], !diff[32]};
        st_d[i].dvd[d] = {st_q[i-1].dvd[d][31:0], 1'b0};
      end
    end

    // Restore the sign and saturate s.
    for (int unsigned d = 0; d < 3; d++) begin
      qe = {17'd0, st_q[bpp_pkg::StgSgn-1].quo[d]};
      st_d[bpp_pkg::StgSgn].s[d] =
        bpp_pkg::sat32(st_q[bpp_pkg::StgSgn-1].neg[d] ? 50'd0 - qe : qe);
    end

    // vp x s products
    for (int unsigned d = 0; d < 3; d++) begin
      a1 = (d == 2) ? 0 : d + 1;
      a2 = (d == 0) ? 2 : d - 1;
      st_d[bpp_pkg::StgRot2].prd[2*d] =
        bpp_pkg::mulq(st_q[bpp_pkg::StgSgn].vp[a1], st_q[bpp_pkg::StgSgn].s[a2]);
      st_d[bpp_pkg::StgRot2].prd[2*d+1] =
        bpp_pkg::mulq(st_q[bpp_pkg::StgSgn].vp[a2], st_q[bpp_pkg::StgSgn].s[a1]);
    end

    // Second rotation; vq is held in the un field until the last kick.
    for (int unsigned d = 0; d < 3; d++) begin
      st_d[bpp_pkg::StgVq].un[d] = bpp_pkg::cross_add(st_q[bpp_pkg::StgRot2].vm[d],
                                                      st_q[bpp_pkg::StgRot2].prd[2*d],
                                                      st_q[bpp_pkg::StgRot2].prd[2*d+1]);
    end

    // Second half kick and speed check
    over = 1'b0;
    for (int unsigned d = 0; d < 3; d++) begin
      st_d[bpp_pkg::StgUn].un[d] =
        bpp_pkg::sat32(bpp_pkg::ext32(st_q[bpp_pkg::StgVq].un[d]) +
                       bpp_pkg::ext32(st_q[bpp_pkg::StgVq].k[d]));
      um = st_d[bpp_pkg::StgUn].un[d][31] ?
           32'd0 - st_d[bpp_pkg::StgUn].un[d] : st_d[bpp_pkg::StgUn].un[d];
      if (um > {1'b0, lim_q[d]}) begin
        over = 1'b1;
      end
    end
    st_d[bpp_pkg::StgUn].over = over;

    // Displacement products
    for (int unsigned d = 0; d < 3; d++) begin
      st_d[bpp_pkg::StgMove].prd[d] = bpp_pkg::mulq(st_q[bpp_pkg::StgUn].un[d], time_step_q);
    end

    // Position update when enabled; otherwise the position passes through.
    for (int unsigned d = 0; d < 3; d++) begin
      if (upd_q) begin
        st_d[bpp_pkg::StgPos].r[d] =
          bpp_pkg::sat32(bpp_pkg::ext32(st_q[bpp_pkg::StgMove].r[d]) +
                         bpp_pkg::ext49(bpp_pkg::rnd16(st_q[bpp_pkg::StgMove].prd[d])));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < bpp_pkg::NumStages; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= valid_i;
      for (int unsigned i = 1; i < bpp_pkg::NumStages; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Payload carries no reset; hold it while the pipeline is frozen.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int unsigned i = 0; i < bpp_pkg::NumStages; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign valid_o          = vld_q[Last];
  assign new_pos_x_o      = st_q[Last].r[0];
  assign new_pos_y_o      = st_q[Last].r[1];
  assign new_pos_z_o      = st_q[Last].r[2];
  assign new_vel_x_o      = st_q[Last].un[0];
  assign new_vel_y_o      = st_q[Last].un[1];
  assign new_vel_z_o      = st_q[Last].un[2];
  assign speed_exceeded_o = st_q[Last].over;

endmodule
